// ----- design/rbd_pkg.sv -----
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants for the 2x2 RGBA box downscaler.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int unsigned CFG_W       = 13;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned PAIR_W      = CHAN_W + 1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
  localparam logic [CFG_W-1:0] DIM_MIN      = CFG_W'(2);

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [CHAN_W-1:0] in_alpha;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_red;
  } pixel_t;

  typedef struct packed {
    logic              frame_last;
    logic [CHAN_W-1:0] out_alpha;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
  } result_t;

  // horizontal pair sums, one line store word
  typedef struct packed {
    logic [PAIR_W-1:0] alpha;
    logic [PAIR_W-1:0] blue;
    logic [PAIR_W-1:0] green;
    logic [PAIR_W-1:0] red;
  } pair_t;

  localparam int unsigned PAIR_WORD_W = $bits(pair_t);

endpackage

// ----- design/rbd_if.sv -----
// ----------------------------------------------------------------------------
// rbd_if
// Valid/ready stream channels for source pixels and downscaled results.
// ----------------------------------------------------------------------------
interface rbd_pixel_if
  import rbd_pkg::*;
  ;
  logic   valid;
  logic   ready;
  pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rbd_result_if
  import rbd_pkg::*;
  ;
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/rbd_ram.sv -----
// ----------------------------------------------------------------------------
// rbd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data while not enabled
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/rgba_box_downscale_2x2.sv -----
// ----------------------------------------------------------------------------
// rgba_box_downscale_2x2
// 2x2 box-filter downscaler for RGBA8888 pixels in raster order.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        word
//  pixel    in   valid/ready      one source pixel (in_red..in_alpha)
//  result   out  valid/ready      one half-size pixel plus frame_last
//  apb      in   psel/penable     source_width @0x0, source_height @0x4
//
// One source pixel is taken per cycle while pixel.ready is high. A result is
// registered twice after its bottom-right source pixel is taken: first the line
// store read, then the final add into the output register. Stalls on result back up through the
// two stages into pixel.ready. Reset (rst, synchronous) or any register
// write restarts the frame at row 0, column 0; the line store keeps its data.
// ----------------------------------------------------------------------------
module rgba_box_downscale_2x2
  import rbd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  rbd_pixel_if.sink             pixel,
  rbd_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CMP_W      = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
  localparam logic [CMP_W-1:0] WIDTH_CAP = CMP_W'(MAX_WIDTH & ~1);

  // --------------------------------------------------------------------------
  // configuration
  logic [CFG_W-1:0] source_width;
  logic [CFG_W-1:0] source_height;
  logic             cfg_wr;
  reg_index_t       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= WIDTH_RESET;
      source_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SOURCE_WIDTH:  source_width  <= pwdata[CFG_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SOURCE_WIDTH:  prdata = APB_DATA_W'(source_width);
      REG_SOURCE_HEIGHT: prdata = APB_DATA_W'(source_height);
      default:           prdata = '0;
    endcase
  end

  // effective frame size: even, at least 2, width capped at the line store
  logic [CMP_W-1:0] width_eff;
  logic [CFG_W-1:0] height_eff;
  logic [CMP_W-1:0] width_even;

  always_comb begin
    width_even = CMP_W'(source_width & ~CFG_W'(1));
    if (width_even < CMP_W'(DIM_MIN)) begin
      width_eff = CMP_W'(DIM_MIN);
    end else if (width_even > WIDTH_CAP) begin
      width_eff = WIDTH_CAP;
    end else begin
      width_eff = width_even;
    end
    height_eff = source_height & ~CFG_W'(1);
    if (height_eff < DIM_MIN) begin
      height_eff = DIM_MIN;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: position counters, pair sums, line store access
  logic [COL_W-1:0] column_count;
  logic [CFG_W-1:0] row_count;
  pixel_t           left_pixel;
  logic             col_last;
  logic             row_last;
  logic             pix_acc;
  logic             emit;
  logic             line_we;
  logic             line_re;
  logic [LINE_AW-1:0] line_addr;
  pair_t            pair_now;
  pair_t            line_rdata;

  assign col_last  = (CMP_W'(column_count) == width_eff - CMP_W'(1));
  assign row_last  = (row_count == height_eff - CFG_W'(1));
  assign pix_acc   = pixel.valid && pixel.ready;
  assign emit      = column_count[0] && row_count[0];
  assign line_we   = pix_acc && column_count[0] && !row_count[0];
  assign line_re   = pix_acc && emit;
  assign line_addr = LINE_AW'(column_count >> 1);

  always_comb begin
    pair_now.red   = PAIR_W'(left_pixel.in_red)   + PAIR_W'(pixel.data.in_red);
    pair_now.green = PAIR_W'(left_pixel.in_green) + PAIR_W'(pixel.data.in_green);
    pair_now.blue  = PAIR_W'(left_pixel.in_blue)  + PAIR_W'(pixel.data.in_blue);
    pair_now.alpha = PAIR_W'(left_pixel.in_alpha) + PAIR_W'(pixel.data.in_alpha);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
    end else if (pix_acc) begin
      if (!column_count[0]) begin
        left_pixel <= pixel.data;
      end
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_count + CFG_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  rbd_ram #(
    .WIDTH (PAIR_WORD_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_we),
    .wr_addr (line_addr),
    .wr_data (pair_now),
    .rd_en   (line_re),
    .rd_addr (line_addr),
    .rd_data (line_rdata)
  );

  // --------------------------------------------------------------------------
  // stage 1: wait for line data; output register
  logic    s1_valid;
  pair_t   s1_pair;
  logic    s1_last;
  logic    out_valid;
  result_t out_data;
  logic    out_load;
  logic    [PAIR_W:0] sum_r, sum_g, sum_b, sum_a;

  assign out_load    = s1_valid && (!out_valid || result.ready);
  assign pixel.ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_acc && emit) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc && emit) begin
      s1_pair <= pair_now;
      s1_last <= col_last && row_last;
    end
  end

  assign sum_r = (PAIR_W+1)'(s1_pair.red)   + (PAIR_W+1)'(line_rdata.red);
  assign sum_g = (PAIR_W+1)'(s1_pair.green) + (PAIR_W+1)'(line_rdata.green);
  assign sum_b = (PAIR_W+1)'(s1_pair.blue)  + (PAIR_W+1)'(line_rdata.blue);
  assign sum_a = (PAIR_W+1)'(s1_pair.alpha) + (PAIR_W+1)'(line_rdata.alpha);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // drop the two low bits: floor of the four-sample mean
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_red    <= sum_r[PAIR_W:2];
      out_data.out_green  <= sum_g[PAIR_W:2];
      out_data.out_blue   <= sum_b[PAIR_W:2];
      out_data.out_alpha  <= sum_a[PAIR_W:2];
      out_data.frame_last <= s1_last;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  a_line_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(line_we && line_re))
    else $error("line store written and read in the same cycle");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(column_count) < width_eff)
    else $error("column counter beyond effective width");

  a_last_on_odd: assert property (@(posedge clk) disable iff (rst)
    (pix_acc && col_last && row_last) |-> (column_count[0] && row_count[0]))
    else $error("frame end on a pixel that closes no block");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_load) |=> (s1_valid && $stable(s1_pair) && $stable(line_rdata)))
    else $error("stalled block sum lost its operands");
`endif

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the 2x2 RGBA box downscaler. Source pixels go in over the
// pixel channel with random gaps. Results are taken with random back-pressure
// and checked against a cycle-free prediction of the block averages. The
// frame size is reprogrammed over APB between phases, including the clamp
// to the minimum size and odd sizes.
// ----------------------------------------------------------------------------
module tb_top;
  import rbd_pkg::*;

  localparam int unsigned LINE_PIXELS  = 4096;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 560;

  class downscale_tracker;
    pair_t            pair_row [LINE_PIXELS/2];
    pixel_t           left_px;
    int unsigned      col;
    int unsigned      row;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    result_t          pending_averages [$];
    int unsigned      mismatches;

    function new();
      left_px    = '0;
      col        = 0;
      row        = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      mismatches = 0;
    endfunction

    // drop the odd bit, clamp to the line store size
    function int unsigned row_len();
      int unsigned w;
      w = {width_reg[CFG_W-1:1], 1'b0};
      if (w < 2) w = 2;
      if (w > LINE_PIXELS) w = LINE_PIXELS;
      return w;
    endfunction

    function int unsigned frame_rows();
      int unsigned h;
      h = {height_reg[CFG_W-1:1], 1'b0};
      if (h < 2) h = 2;
      return h;
    endfunction

    function void set_reg(reg_index_t idx, logic [APB_DATA_W-1:0] value);
      if (idx == REG_SOURCE_WIDTH) begin
        width_reg = value[CFG_W-1:0];
      end else begin
        height_reg = value[CFG_W-1:0];
      end
      left_px = '0;
      col     = 0;
      row     = 0;
    endfunction

    function logic [CHAN_W-1:0] avg4(logic [PAIR_W-1:0] pair, logic [CHAN_W-1:0] a,
                                     logic [CHAN_W-1:0] b);
      logic [CHAN_W+1:0] s;
      s = pair + a + b;
      return s[CHAN_W+1:2];
    endfunction

    function void take_pixel(pixel_t p);
      int unsigned idx;
      result_t     r;
      idx = (col >> 1) % (LINE_PIXELS/2);
      if (!col[0]) begin
        left_px = p;
      end else if (!row[0]) begin
        pair_row[idx].red   = left_px.in_red   + p.in_red;
        pair_row[idx].green = left_px.in_green + p.in_green;
        pair_row[idx].blue  = left_px.in_blue  + p.in_blue;
        pair_row[idx].alpha = left_px.in_alpha + p.in_alpha;
      end else begin
        r.out_red    = avg4(pair_row[idx].red,   left_px.in_red,   p.in_red);
        r.out_green  = avg4(pair_row[idx].green, left_px.in_green, p.in_green);
        r.out_blue   = avg4(pair_row[idx].blue,  left_px.in_blue,  p.in_blue);
        r.out_alpha  = avg4(pair_row[idx].alpha, left_px.in_alpha, p.in_alpha);
        r.frame_last = (row + 1 >= frame_rows()) && (col + 1 >= row_len());
        pending_averages.push_back(r);
      end
      col++;
      if (col >= row_len()) begin
        col = 0;
        row++;
        if (row >= frame_rows()) row = 0;
      end
    endfunction

    function void check_field(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
      if (got !== want) begin
        $error("%s expected %0d actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void compare_average(result_t got);
      result_t want;
      if (pending_averages.size() == 0) begin
        $error("unexpected word: out_red %0d out_green %0d out_blue %0d out_alpha %0d %s %0d",
               got.out_red, got.out_green, got.out_blue, got.out_alpha,
               "frame_last", got.frame_last);
        mismatches++;
        return;
      end
      want = pending_averages.pop_front();
      check_field("out_red",    want.out_red,    got.out_red);
      check_field("out_green",  want.out_green,  got.out_green);
      check_field("out_blue",   want.out_blue,   got.out_blue);
      check_field("out_alpha",  want.out_alpha,  got.out_alpha);
      check_field("frame_last", want.frame_last, got.frame_last);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  bit                    steady;

  downscale_tracker tracker = new();

  rbd_pixel_if  pix_if ();
  rbd_result_if res_if ();

  rgba_box_downscale_2x2 dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pix_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic pixel_t mk_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [7:0] a);
    pixel_t p;
    p.in_red   = r;
    p.in_green = g;
    p.in_blue  = b;
    p.in_alpha = a;
    return p;
  endfunction

  // random upper bits above the size field
  function automatic logic [APB_DATA_W-1:0] reg_word(logic [CFG_W-1:0] v);
    return ($urandom & ~APB_DATA_W'(13'h1FFF)) | APB_DATA_W'(v);
  endfunction

  task automatic send_pixel(pixel_t p);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= p;
    @(posedge clk);
    while (pix_if.ready !== 1'b1) @(posedge clk);
    tracker.take_pixel(p);
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_pixel(pixel_t'($urandom));
  endtask

  // hold until every expected word is out, then let the pipe settle
  task automatic drain();
    pix_if.valid <= 1'b0;
    while (tracker.pending_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [APB_DATA_W-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  initial begin : result_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (res_if.valid !== 1'b1) @(posedge clk);
      tracker.compare_average(res_if.data);
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned sent;
    int unsigned count;
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    pix_if.valid <= 1'b0;
    pix_if.data  <= '0;
    steady = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size 640x480: one full row and the start of the next
    send_random(640 + 16);

    // clamp both sizes up to 2: every four words make a whole frame
    write_reg(REG_SOURCE_WIDTH,  reg_word(13'd1));
    write_reg(REG_SOURCE_HEIGHT, reg_word(13'd0));
    repeat (4) send_pixel(mk_pixel(8'd255, 8'd255, 8'd255, 8'd255));
    repeat (4) send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(mk_pixel(8'd1, 8'd255, 8'd0,   8'd128));
    send_pixel(mk_pixel(8'd1, 8'd255, 8'd255, 8'd128));
    send_pixel(mk_pixel(8'd1, 8'd255, 8'd0,   8'd127));
    send_pixel(mk_pixel(8'd0, 8'd254, 8'd255, 8'd127));

    // odd sizes: trailing column and row drop out
    write_reg(REG_SOURCE_WIDTH,  reg_word(13'd5));
    write_reg(REG_SOURCE_HEIGHT, reg_word(13'd3));
    for (i = 0; i < 8; i++) begin
      send_pixel(mk_pixel(8'(i * 40), 8'(255 - i * 30), 8'(i * i), 8'(i * 17 + 3)));
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin
          write_reg(REG_SOURCE_WIDTH,  reg_word(CFG_W'($urandom_range(0, 20))));
          write_reg(REG_SOURCE_HEIGHT, reg_word(CFG_W'($urandom_range(0, 9))));
        end
        1: write_reg(REG_SOURCE_WIDTH, reg_word(CFG_W'($urandom_range(0, 20))));
        2: begin
          if ($urandom_range(0, 7) == 0) begin
            write_reg(REG_SOURCE_HEIGHT, reg_word(CFG_W'($urandom)));
          end else begin
            write_reg(REG_SOURCE_HEIGHT, reg_word(CFG_W'($urandom_range(0, 9))));
          end
        end
        default: ;
      endcase
      // one to three whole frames plus up to two rows, at most 200 pixels in all
      count = tracker.row_len() * tracker.frame_rows() * $urandom_range(1, 3)
            + $urandom_range(0, 2 * tracker.row_len());
      if (count > 200) count = 200;
      send_random(count);
      sent += count;
    end

    steady = 1'b0;
    drain();
    if (tracker.mismatches == 0) begin
      $display("rgba_box_downscale_2x2: match");
    end else begin
      $display("rgba_box_downscale_2x2: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("rgba_box_downscale_2x2: mismatch");
    $finish;
  end

endmodule
